// File: rtl/core/frame_buffered_lcd_controller_macros.svh
// Assertion macros shared by the LCD frame buffer checker
`ifndef FRAME_BUFFERED_LCD_CONTROLLER_MACROS_SVH
`define FRAME_BUFFERED_LCD_CONTROLLER_MACROS_SVH

// condition implies consequence in the same cycle
`define LCDFB_ASSERT_IMP(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("lcdfb check failed");

// condition implies consequence in the following cycle
`define LCDFB_ASSERT_NXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("lcdfb check failed");

`endif

// File: rtl/core/lcdfb_pkg.sv
// Types, codes and font table for the LCD frame buffer controller
package lcdfb_pkg;

	typedef enum logic [2:0] {
		OP_DATA    = 3'd0,
		OP_CMD     = 3'd1,
		OP_CURSOR  = 3'd2,
		OP_REFRESH = 3'd3,
		OP_TICK    = 3'd4,
		OP_CHAR    = 3'd5,
		OP_OVERLAY = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_BUSY  = 2'd1,
		STAT_RANGE = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ADDR2,
		S_TICK,
		S_CHAR,
		S_OVL
	} state_t;

	localparam logic [7:0] CMD_SET_X  = 8'h80;
	localparam logic [7:0] CMD_SET_Y  = 8'h40;
	localparam logic [7:0] FONT_FIRST = 8'h20;
	localparam logic [7:0] FONT_LAST  = 8'h80;
	localparam logic [2:0] GLYPH_COLS = 3'd5;

	// column 0 of each glyph in the top byte
	localparam logic [39:0] FONT_ROM [97] = '{
		40'h0000000000, 40'h00005f0000, 40'h0007000700,
		40'h147f147f14, 40'h242a7f2a12, 40'h2313086462,
		40'h3649552250, 40'h0005030000, 40'h001c224100,
		40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000,
		40'h2010080402, 40'h3e5149453e, 40'h00427f4000,
		40'h4261514946, 40'h2141454b31, 40'h1814127f10,
		40'h2745454539, 40'h3c4a494930, 40'h0171090503,
		40'h3649494936, 40'h064949291e, 40'h0036360000,
		40'h0056360000, 40'h0814224100, 40'h1414141414,
		40'h0041221408, 40'h0201510906, 40'h324979413e,
		40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
		40'h7f4141221c, 40'h7f49494941, 40'h7f09090901,
		40'h3e4149497a, 40'h7f0808087f, 40'h00417f4100,
		40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
		40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
		40'h7f09090906, 40'h3e4151215e, 40'h7f09192946,
		40'h4649494931, 40'h01017f0101, 40'h3f4040403f,
		40'h1f2040201f, 40'h3f4038403f, 40'h6314081463,
		40'h0708700807, 40'h6151494543, 40'h007f414100,
		40'h0204081020, 40'h0041417f00, 40'h0402010204,
		40'h4040404040, 40'h0001020400, 40'h2054545478,
		40'h7f48444438, 40'h3844444420, 40'h384444487f,
		40'h3854545418, 40'h087e090102, 40'h0c5252523e,
		40'h7f08040478, 40'h00447d4000, 40'h2040443d00,
		40'h7f10284400, 40'h00417f4000, 40'h7c04180478,
		40'h7c08040478, 40'h3844444438, 40'h7c14141408,
		40'h081414187c, 40'h7c08040408, 40'h4854545420,
		40'h043f444020, 40'h3c4040207c, 40'h1c2040201c,
		40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
		40'h4464544c44, 40'h0008364100, 40'h00007f0000,
		40'h0041360800, 40'h1008081008, 40'h7846414678,
		40'h0609090600
	};

	function automatic logic [7:0] font_col(input logic [6:0] g, input logic [2:0] c);
		logic [39:0] w;
		w = FONT_ROM[g];
		return w[(GLYPH_COLS - 3'd1 - c) * 8 +: 8];
	endfunction

endpackage

// File: rtl/core/lcdfb_ram.sv
// Frame store: one write port, one registered read port
module lcdfb_ram #(
	parameter int DEPTH  = 504,
	parameter int ADDR_W = 9
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/frame_buffered_lcd_controller.sv
// LCD frame buffer controller: sequencer around a single-port-pair frame store.
// Results are registered and appear in the cycle after the last step of work; tick and overlay
// first read the store, and refresh start sends two address bytes, the second from S_ADDR2.
// Character write stores a blank column and then five glyph columns, one store write per column.
// After reset all PANEL_COLUMNS*PANEL_ROW_BYTES (504) cells of the store are swept to zero
// with busy high; results are strobed for one cycle and cannot be held off.
module frame_buffered_lcd_controller
	import lcdfb_pkg::*;
#(
	parameter int PANEL_COLUMNS   = 84,
	parameter int PANEL_ROW_BYTES = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] opcode,
	input  logic [7:0] data_byte,
	input  logic [6:0] col_in,
	input  logic [5:0] y_in,
	input  logic       pixel_set,
	output logic       strobe,
	output logic       has_byte,
	output logic [7:0] spi_byte,
	output logic       is_data,
	output logic [1:0] status,
	output logic       frame_done,
	output logic       last
);

	localparam int COL_W  = $clog2(PANEL_COLUMNS);
	localparam int ROW_W  = (PANEL_ROW_BYTES > 1) ? $clog2(PANEL_ROW_BYTES) : 1;
	localparam int DEPTH  = PANEL_COLUMNS * PANEL_ROW_BYTES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [COL_W-1:0]  COL_LAST = COL_W'(PANEL_COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(PANEL_ROW_BYTES - 1);
	localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] c,
			input logic [ROW_W-1:0] r);
		return ADDR_W'(c) * ADDR_W'(PANEL_ROW_BYTES) + ADDR_W'(r);
	endfunction

	function automatic logic [COL_W-1:0] sat_col(input logic [6:0] c);
		if ({1'b0, c} >= 8'(PANEL_COLUMNS)) return COL_LAST;
		return COL_W'(c);
	endfunction

	function automatic logic [ROW_W-1:0] sat_row(input logic [5:0] y);
		logic [2:0] r;
		r = y[5:3];
		if ({1'b0, r} >= 4'(PANEL_ROW_BYTES)) return ROW_LAST;
		return ROW_W'(r);
	endfunction

	function automatic logic [COL_W-1:0] next_col(input logic [COL_W-1:0] c);
		return (c == COL_LAST) ? '0 : c + 1'b1;
	endfunction

	function automatic logic [ROW_W-1:0] next_row(input logic [COL_W-1:0] c,
			input logic [ROW_W-1:0] r);
		if (c != COL_LAST) return r;
		return (r == ROW_LAST) ? '0 : r + 1'b1;
	endfunction

	state_t            state_q, state_d;
	logic [COL_W-1:0]  cur_col_q, cur_col_d, scan_col_q, scan_col_d;
	logic [ROW_W-1:0]  cur_row_q, cur_row_d, scan_row_q, scan_row_d;
	logic              refresh_q, refresh_d, dirty_q, dirty_d;
	logic [ADDR_W-1:0] clr_q, clr_d;

	logic              strobe_q, strobe_d, has_q, has_d, isdata_q, isdata_d;
	logic              done_q, done_d, last_q, last_d;
	logic [7:0]        spi_q, spi_d;
	stat_t             stat_q, stat_d;

	logic [7:0]        byte_q, byte_d;
	logic              pix_q, pix_d, ok_q, ok_d, fdone_q, fdone_d;
	logic [2:0]        k_q, k_d;
	stat_t             pstat_q, pstat_d;
	logic [6:0]        glyph;

	logic              we, re;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [7:0]        wdata, rdata;

	lcdfb_ram #(
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign busy       = (state_q != S_IDLE);
	assign strobe     = strobe_q;
	assign has_byte   = has_q;
	assign spi_byte   = spi_q;
	assign is_data    = isdata_q;
	assign status     = stat_q;
	assign frame_done = done_q;
	assign last       = last_q;

	assign glyph = ok_q ? 7'(byte_q - FONT_FIRST) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			scan_col_q <= '0;
			scan_row_q <= '0;
			refresh_q  <= 1'b0;
			dirty_q    <= 1'b0;
			clr_q      <= '0;
			strobe_q   <= 1'b0;
			has_q      <= 1'b0;
			spi_q      <= '0;
			isdata_q   <= 1'b0;
			stat_q     <= STAT_OK;
			done_q     <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			cur_col_q  <= cur_col_d;
			cur_row_q  <= cur_row_d;
			scan_col_q <= scan_col_d;
			scan_row_q <= scan_row_d;
			refresh_q  <= refresh_d;
			dirty_q    <= dirty_d;
			clr_q      <= clr_d;
			strobe_q   <= strobe_d;
			has_q      <= has_d;
			spi_q      <= spi_d;
			isdata_q   <= isdata_d;
			stat_q     <= stat_d;
			done_q     <= done_d;
			last_q     <= last_d;
		end
	end

	always_ff @(posedge clk) begin
		byte_q  <= byte_d;
		pix_q   <= pix_d;
		ok_q    <= ok_d;
		fdone_q <= fdone_d;
		k_q     <= k_d;
		pstat_q <= pstat_d;
	end

	always_comb begin
		state_d    = state_q;
		cur_col_d  = cur_col_q;
		cur_row_d  = cur_row_q;
		scan_col_d = scan_col_q;
		scan_row_d = scan_row_q;
		refresh_d  = refresh_q;
		dirty_d    = dirty_q;
		clr_d      = clr_q;
		byte_d     = byte_q;
		pix_d      = pix_q;
		ok_d       = ok_q;
		fdone_d    = fdone_q;
		k_d        = k_q;
		pstat_d    = pstat_q;
		strobe_d   = 1'b0;
		has_d      = 1'b0;
		spi_d      = '0;
		isdata_d   = 1'b0;
		stat_d     = STAT_OK;
		done_d     = 1'b0;
		last_d     = 1'b1;
		we         = 1'b0;
		waddr      = cell_addr(cur_col_q, cur_row_q);
		wdata      = '0;
		re         = 1'b0;
		raddr      = cell_addr(scan_col_q, scan_row_q);

		case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				clr_d = clr_q + 1'b1;
				if (clr_q == ADDR_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					byte_d = data_byte;
					pix_d  = pixel_set;
					case (opcode)
						OP_DATA: begin
							strobe_d = 1'b1;
							if (refresh_q) begin
								stat_d = STAT_BUSY;
							end else begin
								we        = 1'b1;
								wdata     = data_byte;
								dirty_d   = 1'b1;
								cur_col_d = next_col(cur_col_q);
								cur_row_d = next_row(cur_col_q, cur_row_q);
							end
						end
						OP_CMD: begin
							strobe_d = 1'b1;
							if (refresh_q) begin
								stat_d = STAT_BUSY;
							end else if (dirty_q) begin
								has_d      = 1'b1;
								spi_d      = CMD_SET_X;
								stat_d     = STAT_BUSY;
								last_d     = 1'b0;
								pstat_d    = STAT_BUSY;
								refresh_d  = 1'b1;
								scan_col_d = '0;
								scan_row_d = '0;
								state_d    = S_ADDR2;
							end else begin
								has_d = 1'b1;
								spi_d = data_byte;
							end
						end
						OP_CURSOR: begin
							strobe_d  = 1'b1;
							cur_col_d = sat_col(col_in);
							cur_row_d = sat_row(y_in);
						end
						OP_REFRESH: begin
							strobe_d = 1'b1;
							if (!refresh_q) begin
								has_d      = 1'b1;
								spi_d      = CMD_SET_X;
								last_d     = 1'b0;
								pstat_d    = STAT_OK;
								refresh_d  = 1'b1;
								scan_col_d = '0;
								scan_row_d = '0;
								state_d    = S_ADDR2;
							end
						end
						OP_TICK: begin
							if (refresh_q) begin
								re         = 1'b1;
								scan_col_d = next_col(scan_col_q);
								scan_row_d = next_row(scan_col_q, scan_row_q);
								fdone_d    = (scan_col_q == COL_LAST) && (scan_row_q == ROW_LAST);
								if (fdone_d) begin
									refresh_d = 1'b0;
									dirty_d   = 1'b0;
								end
								state_d = S_TICK;
							end else begin
								strobe_d = 1'b1;
							end
						end
						OP_CHAR: begin
							if (refresh_q) begin
								strobe_d = 1'b1;
								stat_d   = STAT_BUSY;
							end else begin
								we        = 1'b1;
								dirty_d   = 1'b1;
								cur_col_d = next_col(cur_col_q);
								cur_row_d = next_row(cur_col_q, cur_row_q);
								ok_d      = (data_byte >= FONT_FIRST) && (data_byte <= FONT_LAST);
								k_d       = 3'd1;
								state_d   = S_CHAR;
							end
						end
						OP_OVERLAY: begin
							if (refresh_q) begin
								strobe_d = 1'b1;
								stat_d   = STAT_BUSY;
							end else begin
								cur_col_d = sat_col(col_in);
								cur_row_d = sat_row(y_in);
								re        = 1'b1;
								raddr     = cell_addr(cur_col_d, cur_row_d);
								state_d   = S_OVL;
							end
						end
						default: begin
							strobe_d = 1'b1;
						end
					endcase
				end
			end
			S_ADDR2: begin
				strobe_d = 1'b1;
				has_d    = 1'b1;
				spi_d    = CMD_SET_Y;
				stat_d   = pstat_q;
				state_d  = S_IDLE;
			end
			S_TICK: begin
				strobe_d = 1'b1;
				has_d    = 1'b1;
				spi_d    = rdata;
				isdata_d = 1'b1;
				done_d   = fdone_q;
				state_d  = S_IDLE;
			end
			S_CHAR: begin
				we        = 1'b1;
				wdata     = ok_q ? font_col(glyph, 3'(k_q - 3'd1)) : '0;
				dirty_d   = 1'b1;
				cur_col_d = next_col(cur_col_q);
				cur_row_d = next_row(cur_col_q, cur_row_q);
				k_d       = k_q + 3'd1;
				if (k_q == GLYPH_COLS) begin
					strobe_d = 1'b1;
					stat_d   = ok_q ? STAT_OK : STAT_RANGE;
					state_d  = S_IDLE;
				end
			end
			S_OVL: begin
				we        = 1'b1;
				wdata     = pix_q ? (rdata | byte_q) : (rdata & byte_q);
				dirty_d   = 1'b1;
				cur_col_d = next_col(cur_col_q);
				cur_row_d = next_row(cur_col_q, cur_row_q);
				strobe_d  = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/core/lcdfb_checker.sv
// Port-level checks for the LCD frame buffer controller, bound to the top level
`include "frame_buffered_lcd_controller_macros.svh"

module lcdfb_checker
	import lcdfb_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic       has_byte,
	input logic [7:0] spi_byte,
	input logic       is_data,
	input logic [1:0] status,
	input logic       frame_done,
	input logic       last
);

	`LCDFB_ASSERT_IMP(a_empty_word, clk, arst_n, strobe && !has_byte, spi_byte == 8'h00 && !is_data && !frame_done)
	`LCDFB_ASSERT_IMP(a_done_word, clk, arst_n, strobe && frame_done, has_byte && is_data && last)
	`LCDFB_ASSERT_NXT(a_second_addr, clk, arst_n, strobe && !last, strobe && last && has_byte && !is_data && spi_byte == CMD_SET_Y)
	`LCDFB_ASSERT_NXT(a_accept_resp, clk, arst_n, start && !busy, strobe || busy)
	`LCDFB_ASSERT_IMP(a_range_nobyte, clk, arst_n, strobe && status == STAT_RANGE, !has_byte && last)

endmodule

bind frame_buffered_lcd_controller lcdfb_checker u_lcdfb_checker (.*);

// File: tb/frame_buffered_lcd_controller_checker.sv
`timescale 1ns / 100ps
// Frame buffer predictor and result-word checker for the LCD controller bench
module frame_buffered_lcd_controller_checker
	import lcdfb_pkg::*;
#(
	parameter int PANEL_COLUMNS   = 84,
	parameter int PANEL_ROW_BYTES = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  opcode,
	input  logic [7:0]  data_byte,
	input  logic [6:0]  col_in,
	input  logic [5:0]  y_in,
	input  logic        pixel_set,
	input  logic        strobe,
	input  logic        has_byte,
	input  logic [7:0]  spi_byte,
	input  logic        is_data,
	input  logic [1:0]  status,
	input  logic        frame_done,
	input  logic        last,
	output int unsigned failures,
	output int unsigned words_due
);

	localparam logic [7:0] ADDR_COL_CMD = 8'h80;
	localparam logic [7:0] ADDR_ROW_CMD = 8'h40;
	localparam logic [7:0] GLYPH_FIRST  = 8'h20;
	localparam logic [7:0] GLYPH_LAST   = 8'h80;
	localparam int FRAME_BYTES = PANEL_COLUMNS * PANEL_ROW_BYTES;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] spi_byte;
		logic       is_data;
		logic [1:0] status;
		logic       frame_done;
		logic       last;
	} lcd_word_t;

	lcd_word_t  panel_words [$];
	logic [7:0] frame_copy [FRAME_BYTES];
	int         cur_col, cur_row, scan_col, scan_row;
	bit         refreshing, dirty;

	// five glyph columns per code, leftmost column in the top byte
	function automatic logic [7:0] glyph_column(input logic [7:0] code, input int idx);
		logic [39:0] g;
		case (code)
			8'h20: g = 40'h0000000000; 8'h21: g = 40'h00005f0000; 8'h22: g = 40'h0007000700;
			8'h23: g = 40'h147f147f14; 8'h24: g = 40'h242a7f2a12; 8'h25: g = 40'h2313086462;
			8'h26: g = 40'h3649552250; 8'h27: g = 40'h0005030000; 8'h28: g = 40'h001c224100;
			8'h29: g = 40'h0041221c00; 8'h2a: g = 40'h14083e0814; 8'h2b: g = 40'h08083e0808;
			8'h2c: g = 40'h0050300000; 8'h2d: g = 40'h0808080808; 8'h2e: g = 40'h0060600000;
			8'h2f: g = 40'h2010080402; 8'h30: g = 40'h3e5149453e; 8'h31: g = 40'h00427f4000;
			8'h32: g = 40'h4261514946; 8'h33: g = 40'h2141454b31; 8'h34: g = 40'h1814127f10;
			8'h35: g = 40'h2745454539; 8'h36: g = 40'h3c4a494930; 8'h37: g = 40'h0171090503;
			8'h38: g = 40'h3649494936; 8'h39: g = 40'h064949291e; 8'h3a: g = 40'h0036360000;
			8'h3b: g = 40'h0056360000; 8'h3c: g = 40'h0814224100; 8'h3d: g = 40'h1414141414;
			8'h3e: g = 40'h0041221408; 8'h3f: g = 40'h0201510906; 8'h40: g = 40'h324979413e;
			8'h41: g = 40'h7e1111117e; 8'h42: g = 40'h7f49494936; 8'h43: g = 40'h3e41414122;
			8'h44: g = 40'h7f4141221c; 8'h45: g = 40'h7f49494941; 8'h46: g = 40'h7f09090901;
			8'h47: g = 40'h3e4149497a; 8'h48: g = 40'h7f0808087f; 8'h49: g = 40'h00417f4100;
			8'h4a: g = 40'h2040413f01; 8'h4b: g = 40'h7f08142241; 8'h4c: g = 40'h7f40404040;
			8'h4d: g = 40'h7f020c027f; 8'h4e: g = 40'h7f0408107f; 8'h4f: g = 40'h3e4141413e;
			8'h50: g = 40'h7f09090906; 8'h51: g = 40'h3e4151215e; 8'h52: g = 40'h7f09192946;
			8'h53: g = 40'h4649494931; 8'h54: g = 40'h01017f0101; 8'h55: g = 40'h3f4040403f;
			8'h56: g = 40'h1f2040201f; 8'h57: g = 40'h3f4038403f; 8'h58: g = 40'h6314081463;
			8'h59: g = 40'h0708700807; 8'h5a: g = 40'h6151494543; 8'h5b: g = 40'h007f414100;
			8'h5c: g = 40'h0204081020; 8'h5d: g = 40'h0041417f00; 8'h5e: g = 40'h0402010204;
			8'h5f: g = 40'h4040404040; 8'h60: g = 40'h0001020400; 8'h61: g = 40'h2054545478;
			8'h62: g = 40'h7f48444438; 8'h63: g = 40'h3844444420; 8'h64: g = 40'h384444487f;
			8'h65: g = 40'h3854545418; 8'h66: g = 40'h087e090102; 8'h67: g = 40'h0c5252523e;
			8'h68: g = 40'h7f08040478; 8'h69: g = 40'h00447d4000; 8'h6a: g = 40'h2040443d00;
			8'h6b: g = 40'h7f10284400; 8'h6c: g = 40'h00417f4000; 8'h6d: g = 40'h7c04180478;
			8'h6e: g = 40'h7c08040478; 8'h6f: g = 40'h3844444438; 8'h70: g = 40'h7c14141408;
			8'h71: g = 40'h081414187c; 8'h72: g = 40'h7c08040408; 8'h73: g = 40'h4854545420;
			8'h74: g = 40'h043f444020; 8'h75: g = 40'h3c4040207c; 8'h76: g = 40'h1c2040201c;
			8'h77: g = 40'h3c4030403c; 8'h78: g = 40'h4428102844; 8'h79: g = 40'h0c5050503c;
			8'h7a: g = 40'h4464544c44; 8'h7b: g = 40'h0008364100; 8'h7c: g = 40'h00007f0000;
			8'h7d: g = 40'h0041360800; 8'h7e: g = 40'h1008081008; 8'h7f: g = 40'h7846414678;
			8'h80: g = 40'h0609090600;
			default: g = '0;
		endcase
		return g[39 - 8 * idx -: 8];
	endfunction

	task automatic push_word(input logic has, input logic [7:0] b, input logic d,
			input logic [1:0] st, input logic done, input logic lst);
		lcd_word_t w;
		w.has_byte   = has;
		w.spi_byte   = b;
		w.is_data    = d;
		w.status     = st;
		w.frame_done = done;
		w.last       = lst;
		panel_words.push_back(w);
	endtask

	task automatic store_column(input logic [7:0] v);
		frame_copy[cur_col * PANEL_ROW_BYTES + cur_row] = v;
		dirty = 1'b1;
		cur_col++;
		if (cur_col >= PANEL_COLUMNS) begin
			cur_col = 0;
			cur_row++;
			if (cur_row >= PANEL_ROW_BYTES)
				cur_row = 0;
		end
	endtask

	task automatic place_cursor(input logic [6:0] ci, input logic [5:0] yi);
		int r;
		r = int'(yi >> 3);
		cur_col = (ci >= PANEL_COLUMNS) ? PANEL_COLUMNS - 1 : int'(ci);
		cur_row = (r >= PANEL_ROW_BYTES) ? PANEL_ROW_BYTES - 1 : r;
	endtask

	task automatic begin_frame(input logic [1:0] st);
		refreshing = 1'b1;
		scan_col   = 0;
		scan_row   = 0;
		push_word(1'b1, ADDR_COL_CMD, 1'b0, st, 1'b0, 1'b0);
		push_word(1'b1, ADDR_ROW_CMD, 1'b0, st, 1'b0, 1'b1);
	endtask

	task automatic predict_words(input logic [2:0] op, input logic [7:0] db,
			input logic [6:0] ci, input logic [5:0] yi, input logic px);
		logic [7:0] v;
		logic [1:0] st;
		logic       ok, done, plain;
		st    = STAT_OK;
		plain = 1'b1;
		case (op)
			OP_DATA: begin
				if (refreshing)
					st = STAT_BUSY;
				else
					store_column(db);
			end
			OP_CMD: begin
				if (refreshing) begin
					st = STAT_BUSY;
				end else if (dirty) begin
					begin_frame(STAT_BUSY);
					plain = 1'b0;
				end else begin
					push_word(1'b1, db, 1'b0, STAT_OK, 1'b0, 1'b1);
					plain = 1'b0;
				end
			end
			OP_CURSOR: place_cursor(ci, yi);
			OP_REFRESH: begin
				if (!refreshing) begin
					begin_frame(STAT_OK);
					plain = 1'b0;
				end
			end
			OP_TICK: begin
				if (refreshing) begin
					v    = frame_copy[scan_col * PANEL_ROW_BYTES + scan_row];
					done = 1'b0;
					scan_col++;
					if (scan_col >= PANEL_COLUMNS) begin
						scan_col = 0;
						scan_row++;
						if (scan_row >= PANEL_ROW_BYTES) begin
							scan_row   = 0;
							refreshing = 1'b0;
							dirty      = 1'b0;
							done       = 1'b1;
						end
					end
					push_word(1'b1, v, 1'b1, STAT_OK, done, 1'b1);
					plain = 1'b0;
				end
			end
			OP_CHAR: begin
				if (refreshing) begin
					st = STAT_BUSY;
				end else begin
					ok = (db >= GLYPH_FIRST) && (db <= GLYPH_LAST);
					store_column(8'h00);
					for (int i = 0; i < 5; i++)
						store_column(ok ? glyph_column(db, i) : 8'h00);
					if (!ok)
						st = STAT_RANGE;
				end
			end
			OP_OVERLAY: begin
				if (refreshing) begin
					st = STAT_BUSY;
				end else begin
					place_cursor(ci, yi);
					v = frame_copy[cur_col * PANEL_ROW_BYTES + cur_row];
					v = px ? (v | db) : (v & db);
					store_column(v);
				end
			end
			default: ;
		endcase
		if (plain)
			push_word(1'b0, 8'h00, 1'b0, st, 1'b0, 1'b1);
	endtask

	task automatic check_word();
		lcd_word_t due;
		if (panel_words.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("%0t: unexpected word has=%0b byte=%02h data=%0b status=%0d done=%0b last=%0b",
					$realtime, has_byte, spi_byte, is_data, status, frame_done, last);
		end else begin
			due = panel_words.pop_front();
			if (due.has_byte !== has_byte || due.spi_byte !== spi_byte ||
					due.is_data !== is_data || due.status !== status ||
					due.frame_done !== frame_done || due.last !== last) begin
				failures++;
				if (failures <= 10) begin
					$display("%0t: word mismatch, exp has=%0b byte=%02h data=%0b status=%0d done=%0b last=%0b",
						$realtime, due.has_byte, due.spi_byte, due.is_data, due.status,
						due.frame_done, due.last);
					$display("%0t:                got has=%0b byte=%02h data=%0b status=%0d done=%0b last=%0b",
						$realtime, has_byte, spi_byte, is_data, status, frame_done, last);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_BYTES; i++)
				frame_copy[i] = 8'h00;
			cur_col    = 0;
			cur_row    = 0;
			scan_col   = 0;
			scan_row   = 0;
			refreshing = 1'b0;
			dirty      = 1'b0;
			panel_words.delete();
			failures   = 0;
			words_due  = 0;
		end else begin
			// a strobed word always belongs to an earlier command
			if (strobe)
				check_word();
			if (start && !busy)
				predict_words(opcode, data_byte, col_in, y_in, pixel_set);
			words_due = panel_words.size();
		end
	end

endmodule

// File: tb/frame_buffered_lcd_controller_tb.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the LCD frame buffer controller
module frame_buffered_lcd_controller_tb;
	import lcdfb_pkg::*;

	localparam int PANEL_COLUMNS   = 84;
	localparam int PANEL_ROW_BYTES = 6;
	localparam int FRAME_BYTES     = PANEL_COLUMNS * PANEL_ROW_BYTES;
	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int MIX_WORDS    = 130;
	localparam int CYCLE_LIMIT  = 200000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  opcode;
	logic [7:0]  data_byte;
	logic [6:0]  col_in;
	logic [5:0]  y_in;
	logic        pixel_set;
	logic        strobe;
	logic        has_byte;
	logic [7:0]  spi_byte;
	logic        is_data;
	logic [1:0]  status;
	logic        frame_done;
	logic        last;
	int unsigned failures;
	int unsigned words_due;
	int          idle_pct = 0;
	int          words_sent = 0;
	int          cycles = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	frame_buffered_lcd_controller #(
		.PANEL_COLUMNS  (PANEL_COLUMNS),
		.PANEL_ROW_BYTES(PANEL_ROW_BYTES)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.opcode    (opcode),
		.data_byte (data_byte),
		.col_in    (col_in),
		.y_in      (y_in),
		.pixel_set (pixel_set),
		.strobe    (strobe),
		.has_byte  (has_byte),
		.spi_byte  (spi_byte),
		.is_data   (is_data),
		.status    (status),
		.frame_done(frame_done),
		.last      (last)
	);

	frame_buffered_lcd_controller_checker #(
		.PANEL_COLUMNS  (PANEL_COLUMNS),
		.PANEL_ROW_BYTES(PANEL_ROW_BYTES)
	) i_word_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.opcode    (opcode),
		.data_byte (data_byte),
		.col_in    (col_in),
		.y_in      (y_in),
		.pixel_set (pixel_set),
		.strobe    (strobe),
		.has_byte  (has_byte),
		.spi_byte  (spi_byte),
		.is_data   (is_data),
		.status    (status),
		.frame_done(frame_done),
		.last      (last),
		.failures  (failures),
		.words_due (words_due)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("frame_buffered_lcd_controller_tb failed");
			$finish;
		end
	end

	// entered and left at a falling edge; start stays high into the next word
	task automatic send_word(input logic [2:0] op, input logic [7:0] db,
			input logic [6:0] ci, input logic [5:0] yi, input logic px);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start     <= 1'b1;
		opcode    <= op;
		data_byte <= db;
		col_in    <= ci;
		y_in      <= yi;
		pixel_set <= px;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
		case ((words_sent / 150) % 4)
			1: idle_pct = 53;
			3: idle_pct = 30;
			default: idle_pct = 0;
		endcase
	endtask

	task automatic send_mixed_word(input bit allow_ctrl);
		logic [2:0] op;
		logic [7:0] db;
		logic [6:0] ci;
		int r;
		r  = $urandom_range(99);
		db = 8'($urandom);
		ci = ($urandom_range(99) < 80) ? 7'($urandom_range(PANEL_COLUMNS - 1)) : 7'($urandom);
		if (r < 25)
			op = OP_DATA;
		else if (r < 45)
			op = OP_CHAR;
		else if (r < 65)
			op = OP_OVERLAY;
		else if (r < 78)
			op = OP_CURSOR;
		else if (r < 86)
			op = OP_TICK;
		else if (r < 90)
			op = OP_UNUSED;
		else if (r < 95)
			op = allow_ctrl ? OP_CMD : OP_DATA;
		else
			op = allow_ctrl ? OP_REFRESH : OP_DATA;
		if (op == OP_CHAR && $urandom_range(99) < 75)
			db = 8'($urandom_range(8'h80, 8'h20));
		send_word(op, db, ci, 6'($urandom), 1'($urandom));
	endtask

	// full panel scan with stray commands between the ticks
	task automatic scan_frame();
		int n;
		n = 0;
		send_word(OP_REFRESH, 8'($urandom), 7'($urandom), 6'($urandom), 1'($urandom));
		while (n < FRAME_BYTES) begin
			if ($urandom_range(99) < 5) begin
				send_mixed_word(1'b1);
			end else begin
				send_word(OP_TICK, 8'($urandom), 7'($urandom), 6'($urandom), 1'($urandom));
				n++;
			end
		end
	endtask

	task automatic draw_frame();
		send_word(OP_CMD, 8'($urandom), 7'($urandom), 6'($urandom), 1'($urandom));
		for (int i = 1; i < MIX_WORDS; i++)
			send_mixed_word(i >= MIX_WORDS * 8 / 10);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do
			@(negedge clk);
		while (words_due != 0);
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		opcode    = OP_DATA;
		data_byte = 8'h00;
		col_in    = 7'd0;
		y_in      = 6'd0;
		pixel_set = 1'b0;
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_word(OP_TICK,    8'h00, 7'd0,   6'd0,  1'b0);
		send_word(OP_CMD,     8'hff, 7'h7f,  6'h3f, 1'b1);
		send_word(OP_CMD,     8'h00, 7'd0,   6'd0,  1'b0);
		send_word(OP_DATA,    8'hff, 7'd0,   6'd0,  1'b0);
		send_word(OP_DATA,    8'h00, 7'h7f,  6'h3f, 1'b1);
		// out-of-range cursor saturates to the last cell, next store wraps
		send_word(OP_CURSOR,  8'h00, 7'h7f,  6'h3f, 1'b0);
		send_word(OP_DATA,    8'ha5, 7'd0,   6'd0,  1'b0);
		send_word(OP_CURSOR,  8'h00, 7'd82,  6'd40, 1'b1);
		send_word(OP_CHAR,    8'h20, 7'd0,   6'd0,  1'b0);
		send_word(OP_CHAR,    8'h80, 7'd0,   6'd0,  1'b0);
		send_word(OP_CHAR,    8'h1f, 7'd0,   6'd0,  1'b0);
		send_word(OP_CHAR,    8'h81, 7'd0,   6'd0,  1'b0);
		send_word(OP_CHAR,    8'hff, 7'd0,   6'd0,  1'b0);
		send_word(OP_OVERLAY, 8'hf0, 7'd0,   6'd0,  1'b1);
		send_word(OP_OVERLAY, 8'h0f, 7'h7f,  6'h3f, 1'b0);
		send_word(OP_OVERLAY, 8'h5a, 7'd83,  6'd47, 1'b1);
		send_word(OP_UNUSED,  8'hff, 7'h7f,  6'h3f, 1'b1);
		// command on a dirty buffer kicks off a refresh
		send_word(OP_CMD,     8'h21, 7'd0,   6'd0,  1'b0);
		send_word(OP_REFRESH, 8'h00, 7'd0,   6'd0,  1'b0);
		send_word(OP_DATA,    8'h3c, 7'd0,   6'd0,  1'b0);
		send_word(OP_CHAR,    8'h41, 7'd0,   6'd0,  1'b0);
		send_word(OP_OVERLAY, 8'hff, 7'd10,  6'd8,  1'b1);
		send_word(OP_CMD,     8'h0c, 7'd0,   6'd0,  1'b0);
		send_word(OP_CURSOR,  8'h00, 7'd5,   6'd20, 1'b0);
		send_word(OP_TICK,    8'h00, 7'd0,   6'd0,  1'b0);

		scan_frame();
		draw_frame();
		wait_drained();

		repeat (20)
			@(posedge clk);
		if (failures == 0)
			$display("frame_buffered_lcd_controller_tb passed");
		else
			$display("frame_buffered_lcd_controller_tb failed");
		$finish;
	end

endmodule
